@@ sv/pcxrle_pkg.sv @@
// Shared types and constants for the PCX run-length encoder.
package pcxrle_pkg;

	localparam int RUN_W        = 6;
	localparam int MAX_RUN_DEF  = 63;
	localparam int QUEUE_DEPTH  = 4;

	localparam logic [7:0] COUNT_MARK    = 8'hC0;
	localparam logic [7:0] LITERAL_LIMIT = 8'd192;

	// Emit slots of one command, in stream order
	localparam logic [1:0] SLOT_MARK_A = 2'd0;
	localparam logic [1:0] SLOT_VAL_A  = 2'd1;
	localparam logic [1:0] SLOT_MARK_B = 2'd2;
	localparam logic [1:0] SLOT_VAL_B  = 2'd3;

	// Input word: one pixel
	typedef struct packed {
		logic [7:0] pixel;
		logic       row_end;
	} pix_word_t;

	// Output word: one encoded byte
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} code_word_t;

	// One run to flush
	typedef struct packed {
		logic             en;
		logic [7:0]       value;
		logic [RUN_W-1:0] count;
	} flush_t;

	// Command from front to back: old-run flush, then row-end flush
	typedef struct packed {
		flush_t a;
		flush_t b;
	} flush_cmd_t;

	// A flush needs a count byte when the run is longer than one or the value
	// would read as a count byte itself
	function automatic logic needs_mark(input flush_t f);
		return (f.count > RUN_W'(1)) || (f.value >= LITERAL_LIMIT);
	endfunction

	function automatic logic [7:0] mark_byte(input flush_t f);
		return COUNT_MARK + {{(8-RUN_W){1'b0}}, f.count};
	endfunction

endpackage

@@ sv/pcxrle_front.sv @@
// Front end: tracks the open run and turns each pixel into flush commands.
module pcxrle_front
	import pcxrle_pkg::*;
#(
	parameter int MAX_RUN = MAX_RUN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pixel_valid,
	output logic       pixel_stall,
	input  pix_word_t  pixel_word,
	input  logic       queue_full,
	output logic       push,
	output flush_cmd_t push_cmd
);

	logic [7:0]       run_value_q;
	logic [RUN_W-1:0] run_length_q;

	logic             accept;
	logic             brk;
	logic             open_new;
	logic [7:0]       new_value;
	logic [RUN_W-1:0] new_length;

	assign pixel_stall = queue_full;
	assign accept      = pixel_valid && !queue_full;

	// Classify the pixel against the open run
	always_comb begin
		brk        = (run_length_q != '0) &&
		             ((pixel_word.pixel != run_value_q) ||
		              (run_length_q >= RUN_W'(MAX_RUN)));
		open_new   = (run_length_q == '0) || brk;
		new_value  = open_new ? pixel_word.pixel : run_value_q;
		new_length = open_new ? RUN_W'(1) : run_length_q + RUN_W'(1);

		push_cmd.a.en    = brk;
		push_cmd.a.value = run_value_q;
		push_cmd.a.count = run_length_q;
		push_cmd.b.en    = pixel_word.row_end;
		push_cmd.b.value = new_value;
		push_cmd.b.count = new_length;

		push = accept && (brk || pixel_word.row_end);
	end

	// Run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_value_q  <= '0;
			run_length_q <= '0;
		end else if (accept) begin
			run_value_q  <= new_value;
			run_length_q <= pixel_word.row_end ? '0 : new_length;
		end
	end

endmodule

@@ sv/pcxrle_queue.sv @@
// Small command queue between front and back.
module pcxrle_queue
	import pcxrle_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  flush_cmd_t push_cmd,
	output logic       full,
	input  logic       pop,
	output logic       head_valid,
	output flush_cmd_t head_cmd
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	flush_cmd_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ sv/pcxrle_back.sv @@
// Back end: walks a flush command byte by byte into the output register.
module pcxrle_back
	import pcxrle_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  flush_cmd_t head_cmd,
	output logic       pop,
	output logic       code_valid,
	input  logic       code_stall,
	output code_word_t code_word
);

	logic [1:0]  slot_q;
	logic        out_valid_q;
	code_word_t  out_word_q;

	logic [3:0]  slot_en;
	logic [3:0]  avail;
	logic [1:0]  cur;
	logic        is_last;
	logic        load;
	logic [7:0]  cur_byte;

	// Pick the current slot and whether any byte follows it
	always_comb begin
		slot_en[SLOT_MARK_A] = head_cmd.a.en && needs_mark(head_cmd.a);
		slot_en[SLOT_VAL_A]  = head_cmd.a.en;
		slot_en[SLOT_MARK_B] = head_cmd.b.en && needs_mark(head_cmd.b);
		slot_en[SLOT_VAL_B]  = head_cmd.b.en;

		for (int i = 0; i < 4; i++) begin
			avail[i] = slot_en[i] && (2'(i) >= slot_q);
		end
		cur = SLOT_VAL_B;
		for (int i = 3; i >= 0; i--) begin
			if (avail[i]) begin
				cur = 2'(i);
			end
		end
		is_last = 1'b1;
		for (int i = 0; i < 4; i++) begin
			if (slot_en[i] && (2'(i) > cur)) begin
				is_last = 1'b0;
			end
		end

		unique case (cur)
			SLOT_MARK_A: cur_byte = mark_byte(head_cmd.a);
			SLOT_VAL_A:  cur_byte = head_cmd.a.value;
			SLOT_MARK_B: cur_byte = mark_byte(head_cmd.b);
			SLOT_VAL_B:  cur_byte = head_cmd.b.value;
			default:     cur_byte = head_cmd.b.value;
		endcase

		load = head_valid && (!out_valid_q || !code_stall);
		pop  = load && is_last;
	end

	// Slot pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= SLOT_MARK_A;
		end else if (load) begin
			slot_q <= is_last ? SLOT_MARK_A : cur + 2'd1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!code_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_word_q.out_byte <= cur_byte;
			out_word_q.last     <= is_last;
		end
	end

	assign code_valid = out_valid_q;
	assign code_word  = out_word_q;

endmodule

@@ sv/pcx_rle_encoder_top.sv @@
// Top level of the PCX run-length encoder.
//
// Pixel channel (pixel_valid / pixel_stall / pixel_word) takes one palette
// pixel per word with a row_end flag on the last pixel of each row. Code
// channel (code_valid / code_stall / code_word) gives the encoded stream one
// byte per word; last marks the final byte caused by a pixel.
// The front end classifies a pixel in the cycle it is accepted and, when a
// run closes or the row ends, pushes a flush command (one or two runs) into a
// QDEPTH-entry queue. The back end turns a command into one to four bytes,
// one byte per cycle while code_stall allows, into a registered output. The
// first byte of a pixel passes through the queue and then the output register.
// A pixel that flushes nothing pushes no command; otherwise the output port
// sets the rate, and a pixel can emit up to four bytes. The queue lets the
// front keep taking pixels while the back drains earlier commands.
// Reset clears the open run and empties the queue and output register.
// A stall on the code channel holds the current byte; once the queue fills,
// pixel_stall rises.
module pcx_rle_encoder_top
	import pcxrle_pkg::*;
#(
	parameter int MAX_RUN = MAX_RUN_DEF,
	parameter int QDEPTH  = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pixel_valid,
	output logic       pixel_stall,
	input  pix_word_t  pixel_word,
	output logic       code_valid,
	input  logic       code_stall,
	output code_word_t code_word
);

	logic       push;
	logic       pop;
	logic       queue_full;
	logic       head_valid;
	flush_cmd_t push_cmd;
	flush_cmd_t head_cmd;

	pcxrle_front #(
		.MAX_RUN(MAX_RUN)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel_word (pixel_word),
		.queue_full (queue_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	pcxrle_queue #(
		.DEPTH(QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (queue_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_cmd  (head_cmd)
	);

	pcxrle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_cmd  (head_cmd),
		.pop       (pop),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.code_word (code_word)
	);

endmodule
